// ===== rtl/sorted_point_table_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted point table assertion macros
// Shorthand for clocked concurrent checks; expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef SORTED_POINT_TABLE_MACROS_SVH
`define SORTED_POINT_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPT_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_point_table: same-cycle check failed");

// next-cycle implication, disabled during reset
`define SPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_point_table: next-cycle check failed");

`endif

// ===== rtl/spt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted point table package
// Sizes, entry layout, request kinds and status codes shared by the table and
// its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spt_pkg;

  localparam int MAX_POINTS = 16;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int COORD_W    = 32;
  localparam int IDX_W      = 4;
  localparam int POS_W      = 4;
  localparam int PCNT_W     = 5;
  localparam int STATUS_W   = 2;

  // width that holds both a request index and the fill count
  localparam int CMP_W      = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic {
    KIND_ADD    = 1'b0,
    KIND_DELETE = 1'b1
  } kind_t;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UPDATED   = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  localparam int POINT_W = $bits(point_t);

endpackage

// ===== rtl/sorted_point_table.sv =====
// ----------------------------------------------------------------------------
// Sorted point table
// Table of (x, y) Q16.16 points kept in ascending x order in one RAM.
// Add updates an equal x or, unless full, inserts with an upward shift; delete
// removes a valid entry and shifts the rest down.
// ----------------------------------------------------------------------------
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    kind, x_value, y_value, point_index
//   out      out  out_valid/out_stall  position, point_count, status
//
// One request at a time; in_stall is high from accept until the result is
// loaded into the output register. The RAM port sets the pace: one entry per
// cycle. An insert scans, shifts the entries above the slot up and writes the
// new entry; an update scans and rewrites y; a full table scans and rejects;
// a delete shifts the entries above the index down; a bad index is rejected.
// Reset clears the state, the fill count and out_valid; no clearing pass is needed.
// A stalled result holds its beat while the next request is already accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_point_table import spt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic signed [COORD_W-1:0] x_value,
  input  logic signed [COORD_W-1:0] y_value,
  input  logic [IDX_W-1:0]          point_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [POS_W-1:0]          position,
  output logic [PCNT_W-1:0]         point_count,
  output status_t                   status
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_ISHIFT = 6'b000100,
    S_IWRITE = 6'b001000,
    S_DSHIFT = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t                    state, state_next;
  logic [CNT_W-1:0]          cnt, cnt_next;
  logic [ADDR_W-1:0]         ptr, ptr_next;
  logic [ADDR_W-1:0]         ins_at, ins_at_next;
  logic [ADDR_W-1:0]         res_pos, res_pos_next;
  status_t                   res_status, res_status_next;
  logic signed [COORD_W-1:0] req_x, req_y;

  point_t            rd_data, wr_data;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              wr_en;

  logic              accept, out_free;
  logic [CNT_W-1:0]  ptr_ext, ptr_p1, ptr_p2, cnt_m1;
  logic [CMP_W-1:0]  idx_ext, cnt_cmp;
  logic              x_hit, x_less;
  logic              place;
  logic [CNT_W-1:0]  place_at;

  spt_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign ptr_ext  = CNT_W'(ptr);
  assign ptr_p1   = ptr_ext + CNT_W'(1);
  assign ptr_p2   = ptr_ext + CNT_W'(2);
  assign cnt_m1   = cnt - CNT_W'(1);
  assign idx_ext  = CMP_W'(point_index);
  assign cnt_cmp  = CMP_W'(cnt);

  assign x_hit    = (rd_data.x == req_x);
  assign x_less   = ($signed(rd_data.x) < req_x);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    ptr_next        = ptr;
    ins_at_next     = ins_at;
    res_pos_next    = res_pos;
    res_status_next = res_status;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = ptr;
    wr_data         = rd_data;
    place           = 1'b0;
    place_at        = cnt;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_pos_next    = '0;
          res_status_next = ST_OK;
          case (kind)
            KIND_ADD: begin
              if (cnt == '0) begin
                ins_at_next = '0;
                state_next  = S_IWRITE;
              end else begin
                ptr_next   = '0;
                state_next = S_SEARCH;
              end
            end
            KIND_DELETE: begin
              if (idx_ext >= cnt_cmp) begin
                res_status_next = ST_BAD_INDEX;
                state_next      = S_FINISH;
              end else if ((idx_ext + CMP_W'(1)) < cnt_cmp) begin
                ptr_next   = ADDR_W'(idx_ext);
                rd_addr    = ADDR_W'(idx_ext + CMP_W'(1));
                state_next = S_DSHIFT;
              end else begin
                // last entry: nothing to move
                cnt_next   = cnt_m1;
                state_next = S_FINISH;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      // rd_data holds entry ptr; stop at the first x not below the request
      S_SEARCH: begin
        if (!x_less) begin
          if (x_hit) begin
            wr_en           = 1'b1;
            wr_addr         = ptr;
            wr_data.x       = rd_data.x;
            wr_data.y       = req_y;
            res_pos_next    = ptr;
            res_status_next = ST_UPDATED;
            state_next      = S_FINISH;
          end else begin
            place    = 1'b1;
            place_at = ptr_ext;
          end
        end else if (ptr_p1 == cnt) begin
          place    = 1'b1;
          place_at = cnt;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
          rd_addr  = ADDR_W'(ptr_p1);
        end
      end

      // move entry ptr up one slot, walking down to the insert slot
      S_ISHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(ptr_p1);
        wr_data = rd_data;
        if (ptr == ins_at) begin
          state_next = S_IWRITE;
        end else begin
          ptr_next = ptr - ADDR_W'(1);
          rd_addr  = ptr - ADDR_W'(1);
        end
      end

      S_IWRITE: begin
        wr_en           = 1'b1;
        wr_addr         = ins_at;
        wr_data.x       = req_x;
        wr_data.y       = req_y;
        cnt_next        = cnt + CNT_W'(1);
        res_pos_next    = ins_at;
        res_status_next = ST_OK;
        state_next      = S_FINISH;
      end

      // rd_data holds entry ptr + 1; move it down into ptr
      S_DSHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ptr;
        wr_data = rd_data;
        if (ptr_p2 == cnt) begin
          cnt_next   = cnt_m1;
          state_next = S_FINISH;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
          rd_addr  = ADDR_W'(ptr_p2);
        end
      end

      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // no equal x: insert at place_at unless the table is full
    if (place) begin
      if (cnt == CNT_W'(MAX_POINTS)) begin
        res_status_next = ST_FULL;
        state_next      = S_FINISH;
      end else if (place_at == cnt) begin
        ins_at_next = ADDR_W'(place_at);
        state_next  = S_IWRITE;
      end else begin
        ins_at_next = ADDR_W'(place_at);
        ptr_next    = ADDR_W'(cnt_m1);
        rd_addr     = ADDR_W'(cnt_m1);
        state_next  = S_ISHIFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    ins_at     <= ins_at_next;
    res_pos    <= res_pos_next;
    res_status <= res_status_next;
    if (accept) begin
      req_x <= x_value;
      req_y <= y_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      position    <= POS_W'(res_pos);
      point_count <= PCNT_W'(cnt);
      status      <= res_status;
    end
  end

endmodule

// ===== rtl/spt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/spt_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted point table checker
// Port-level checks on request pacing and result codes, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_point_table_macros.svh"

module spt_checker import spt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [POS_W-1:0]  position,
  input logic [PCNT_W-1:0] point_count,
  input status_t           status
);

  logic rejected;

  assign rejected = (status == ST_FULL) || (status == ST_BAD_INDEX);

  // one request in flight: the input side closes right after a beat
  `SPT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // rejected requests report position zero
  `SPT_ASSERT_IMPLY(a_reject_pos_zero, out_valid && rejected, position == '0)

  // a full rejection only happens with every slot taken
  `SPT_ASSERT_IMPLY(a_full_count, out_valid && status == ST_FULL, point_count == PCNT_W'(MAX_POINTS))

  // a stalled result beat holds
  `SPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(point_count) && $stable(status))

endmodule

bind sorted_point_table spt_checker u_spt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .position    (position),
  .point_count (point_count),
  .status      (status)
);
